// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, constants and controller/datapath command types.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int unsigned POOL_BYTES    = 65536;
   localparam int unsigned GRANULE_BYTES = 16;
   localparam int unsigned HEADER_BYTES  = 16;

   localparam int unsigned POOL_LOG2 = $clog2(POOL_BYTES);
   localparam int unsigned GRAN_LOG2 = $clog2(GRANULE_BYTES);
   localparam int unsigned NSLOTS    = POOL_BYTES / GRANULE_BYTES;
   localparam int unsigned SLOT_W    = $clog2(NSLOTS);
   // offsets carry one extra bit so that the pool end is representable
   localparam int unsigned OFF_W     = POOL_LOG2 + 1;
   localparam int unsigned NEED_W    = 35;

   localparam logic [4:0] POOL_LG = 5'(POOL_LOG2);

   // memory entry: {free, size_log2}
   localparam int unsigned ENT_W = 6;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_READ,
      CMD_WRITE
   } mem_op_type;

   typedef struct packed {
      mem_op_type             op;
      logic [SLOT_W-1:0]      addr;
      logic                   wr_free;
      logic [4:0]             wr_lg;
   } mem_cmd_type;

   typedef struct packed {
      logic                   rd_free;
      logic [4:0]             rd_lg;
   } mem_sts_type;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [OFF_W-1:0] off);
      return off[GRAN_LOG2 +: SLOT_W];
   endfunction

   function automatic logic [OFF_W-1:0] bsize(input logic [4:0] lg);
      return (lg > 5'(POOL_LOG2)) ? '0 : OFF_W'(1) << lg;
   endfunction

endpackage

// ===== rtl/bba_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_req_if / bba_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface bba_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [16:0] elem_bytes;
   logic [16:0] elem_count;
   logic [15:0] release_offset;
   modport source (output valid, mode, elem_bytes, elem_count, release_offset, input ready);
   modport sink   (input valid, mode, elem_bytes, elem_count, release_offset, output ready);
endinterface

interface bba_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] payload_offset;
   logic        success;
   modport source (output valid, payload_offset, success, input ready);
   modport sink   (input valid, payload_offset, success, output ready);
endinterface

// ===== rtl/bba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/bba_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_datapath
// Header memory: block size and free mark per slot; entry 0 is overridden
// by a reset-initialised shadow so that no clearing pass is needed.
// ----------------------------------------------------------------------------
module bba_datapath
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_cmd_type cmd,
   output mem_sts_type sts
);
   logic [ENT_W-1:0] rd_data;
   logic [ENT_W-1:0] root_ff, root_in;
   logic             rd_root_ff, rd_root_in;
   logic             wr_en;

   assign wr_en = (cmd.op == CMD_WRITE);

   bba_ram #(.WIDTH(ENT_W), .DEPTH(NSLOTS)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .addr   (cmd.addr),
      .wr_data({cmd.wr_free, cmd.wr_lg}),
      .rd_data(rd_data)
   );

   always_comb begin
      root_in    = root_ff;
      if (wr_en && cmd.addr == '0) begin
         root_in = {cmd.wr_free, cmd.wr_lg};
      end
      rd_root_in = (cmd.addr == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= {1'b1, POOL_LG};
      end else begin
         root_ff <= root_in;
      end
      rd_root_ff <= rd_root_in;
   end

   // entry 0 lives in flops so reset state holds without sweeping memory
   assign sts = rd_root_ff ? mem_sts_type'(root_ff) : mem_sts_type'(rd_data);
endmodule

// ===== rtl/bba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for search, split, coalescing passes and release lookups.
// ----------------------------------------------------------------------------
module bba_ctrl
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bba_req_if.sink     req,
   bba_rsp_if.source   rsp,
   output mem_cmd_type cmd,
   input  mem_sts_type sts
);
   typedef enum logic [5:0] {
      S_IDLE, S_MUL, S_CHK,
      // find_best
      F_START, F_RB0, F_WB0, F_RA, F_WA, F_RB, F_WB, F_EVAL, F_WMRG,
      F_NRD, F_NWT, F_NEXT2,
      // split
      P_RD, P_WT, P_CHK, P_W1, P_W2, P_DONE,
      // coalesce
      C_START, C_RA, C_WA, C_RB, C_WB, C_EVAL, C_WMRG, C_NRD, C_NWT, C_NEXT2, C_END,
      // release
      R_RD, R_WT, R_MARK,
      S_RSP
   } state_type;

   state_type         state_ff;
   logic              mode_ff;
   logic [16:0]       eb_ff, ec_ff;
   logic [15:0]       rel_ff;
   logic [NEED_W-1:0] need_ff;
   logic              second_ff;
   logic [OFF_W-1:0]  blk_ff, bud_ff, best_ff, cur_ff;
   logic [4:0]        blg_ff, bestlg_ff, plg_ff;
   logic              bfr_ff, have_ff, quiet_ff;
   logic [SLOT_W:0]   pass_ff;
   logic              rvalid_ff, rsucc_ff;
   logic [15:0]       roff_ff;

   assign req.ready          = (state_ff == S_IDLE) && !rvalid_ff;
   assign rsp.valid          = rvalid_ff;
   assign rsp.payload_offset = roff_ff;
   assign rsp.success        = rsucc_ff;

   function automatic logic fits(input logic [NEED_W-1:0] n, input logic [4:0] l);
      return n <= NEED_W'(bsize(l));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
         cmd       <= '{op: CMD_NONE, addr: '0, wr_free: 1'b0, wr_lg: '0};
      end else begin
         cmd.op <= CMD_NONE;
         if (rvalid_ff && rsp.ready) begin
            rvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  mode_ff   <= req.mode;
                  eb_ff     <= req.elem_bytes;
                  ec_ff     <= req.elem_count;
                  rel_ff    <= req.release_offset;
                  second_ff <= 1'b0;
                  roff_ff   <= '0;
                  rsucc_ff  <= 1'b0;
                  state_ff  <= S_MUL;
               end
            end
            S_MUL: begin
               need_ff  <= NEED_W'(eb_ff * ec_ff) + NEED_W'(HEADER_BYTES);
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (mode_ff) begin
                  if (rel_ff < 16'(HEADER_BYTES)) begin
                     state_ff <= S_RSP;
                  end else begin
                     cur_ff   <= '0;
                     state_ff <= R_RD;
                  end
               end else if (need_ff > NEED_W'(POOL_BYTES)) begin
                  state_ff <= S_RSP;
               end else begin
                  state_ff <= F_START;
               end
            end
            // ---------------- find_best ----------------
            F_START: begin
               blk_ff   <= '0;
               have_ff  <= 1'b0;
               cmd.op   <= CMD_READ;
               cmd.addr <= '0;
               state_ff <= F_RB0;
            end
            F_RB0: state_ff <= F_WB0;
            F_WB0: begin
               blg_ff <= sts.rd_lg;
               bfr_ff <= sts.rd_free;
               bud_ff <= bsize(sts.rd_lg);
               if (bsize(sts.rd_lg) == OFF_W'(POOL_BYTES) && sts.rd_free) begin
                  best_ff  <= '0;
                  state_ff <= P_RD;
               end else if (bsize(sts.rd_lg) >= OFF_W'(POOL_BYTES)) begin
                  state_ff <= P_DONE;
                  have_ff  <= 1'b0;
               end else begin
                  cmd.op   <= CMD_READ;
                  cmd.addr <= slot_of(bsize(sts.rd_lg));
                  state_ff <= F_WB;
               end
            end
            F_RA: begin
               cmd.op   <= CMD_READ;
               cmd.addr <= slot_of(blk_ff);
               state_ff <= F_WA;
            end
            F_WA: state_ff <= F_RB;
            F_RB: begin
               blg_ff   <= sts.rd_lg;
               bfr_ff   <= sts.rd_free;
               bud_ff   <= blk_ff + bsize(sts.rd_lg);
               if (blk_ff + bsize(sts.rd_lg) >= OFF_W'(POOL_BYTES)) begin
                  state_ff <= P_DONE;
               end else begin
                  cmd.op   <= CMD_READ;
                  cmd.addr <= slot_of(blk_ff + bsize(sts.rd_lg));
                  state_ff <= F_WB;
               end
            end
            F_WB: state_ff <= F_EVAL;
            F_EVAL: begin
               if (bfr_ff && sts.rd_free && blg_ff == sts.rd_lg) begin
                  cmd.op      <= CMD_WRITE;
                  cmd.addr    <= slot_of(blk_ff);
                  cmd.wr_free <= 1'b1;
                  cmd.wr_lg   <= blg_ff + 5'd1;
                  if (fits(need_ff, blg_ff + 5'd1) &&
                      (!have_ff || bsize(blg_ff + 5'd1) <= bsize(bestlg_ff))) begin
                     best_ff   <= blk_ff;
                     bestlg_ff <= blg_ff + 5'd1;
                     have_ff   <= 1'b1;
                  end
                  blk_ff   <= bud_ff + bsize(sts.rd_lg);
                  state_ff <= F_NEXT2;
               end else begin
                  if (sts.rd_free && fits(need_ff, sts.rd_lg) &&
                      (!((bfr_ff && fits(need_ff, blg_ff) &&
                          (!have_ff || bsize(blg_ff) < bsize(bestlg_ff))) ||
                         have_ff) ||
                       bsize(sts.rd_lg) <
                       ((bfr_ff && fits(need_ff, blg_ff) &&
                         (!have_ff || bsize(blg_ff) < bsize(bestlg_ff)))
                        ? bsize(blg_ff) : bsize(bestlg_ff)))) begin
                     best_ff   <= bud_ff;
                     bestlg_ff <= sts.rd_lg;
                     have_ff   <= 1'b1;
                  end else if (bfr_ff && fits(need_ff, blg_ff) &&
                               (!have_ff || bsize(blg_ff) < bsize(bestlg_ff))) begin
                     best_ff   <= blk_ff;
                     bestlg_ff <= blg_ff;
                     have_ff   <= 1'b1;
                  end
                  if (blg_ff < sts.rd_lg) begin
                     blk_ff   <= bud_ff + bsize(sts.rd_lg);
                     state_ff <= F_NEXT2;
                  end else begin
                     // slide: buddy becomes block, its header already known
                     blk_ff   <= bud_ff;
                     blg_ff   <= sts.rd_lg;
                     bfr_ff   <= sts.rd_free;
                     bud_ff   <= bud_ff + bsize(sts.rd_lg);
                     if (bud_ff + bsize(sts.rd_lg) >= OFF_W'(POOL_BYTES)) begin
                        state_ff <= P_DONE;
                     end else begin
                        cmd.op   <= CMD_READ;
                        cmd.addr <= slot_of(bud_ff + bsize(sts.rd_lg));
                        state_ff <= F_WB;
                     end
                  end
               end
            end
            F_NEXT2: begin
               if (blk_ff >= OFF_W'(POOL_BYTES)) begin
                  state_ff <= P_DONE;
               end else begin
                  state_ff <= F_RA;
               end
            end
            // ---------------- split ----------------
            P_RD: begin
               cmd.op   <= CMD_READ;
               cmd.addr <= slot_of(best_ff);
               state_ff <= P_WT;
            end
            P_WT: state_ff <= P_CHK;
            P_CHK: begin
               plg_ff <= sts.rd_lg;
               if ((need_ff << 1) < NEED_W'(bsize(sts.rd_lg)) &&
                   (bsize(sts.rd_lg) >> 1) >= OFF_W'(GRANULE_BYTES)) begin
                  cmd.op      <= CMD_WRITE;
                  cmd.addr    <= slot_of(best_ff);
                  cmd.wr_free <= sts.rd_free;
                  cmd.wr_lg   <= sts.rd_lg - 5'd1;
                  state_ff    <= P_W1;
               end else begin
                  if (fits(need_ff, sts.rd_lg)) begin
                     cmd.op      <= CMD_WRITE;
                     cmd.addr    <= slot_of(best_ff);
                     cmd.wr_free <= 1'b0;
                     cmd.wr_lg   <= sts.rd_lg;
                     roff_ff     <= 16'(best_ff + OFF_W'(HEADER_BYTES));
                     rsucc_ff    <= 1'b1;
                  end
                  state_ff <= S_RSP;
               end
            end
            P_W1: begin
               best_ff     <= best_ff + bsize(plg_ff - 5'd1);
               cmd.op      <= CMD_WRITE;
               cmd.addr    <= slot_of(best_ff + bsize(plg_ff - 5'd1));
               cmd.wr_free <= 1'b1;
               cmd.wr_lg   <= plg_ff - 5'd1;
               state_ff    <= P_W2;
            end
            P_W2: state_ff <= P_RD;
            P_DONE: begin
               if (have_ff) begin
                  state_ff <= P_RD;
               end else if (!second_ff) begin
                  second_ff <= 1'b1;
                  pass_ff   <= '0;
                  state_ff  <= C_START;
               end else begin
                  state_ff <= S_RSP;
               end
            end
            // ---------------- coalesce ----------------
            C_START: begin
               blk_ff   <= '0;
               quiet_ff <= 1'b1;
               state_ff <= C_RA;
            end
            C_RA: begin
               cmd.op   <= CMD_READ;
               cmd.addr <= slot_of(blk_ff);
               state_ff <= C_WA;
            end
            C_WA: state_ff <= C_RB;
            C_RB: begin
               blg_ff <= sts.rd_lg;
               bfr_ff <= sts.rd_free;
               bud_ff <= blk_ff + bsize(sts.rd_lg);
               if (blk_ff + bsize(sts.rd_lg) >= OFF_W'(POOL_BYTES)) begin
                  state_ff <= C_END;
               end else begin
                  cmd.op   <= CMD_READ;
                  cmd.addr <= slot_of(blk_ff + bsize(sts.rd_lg));
                  state_ff <= C_WB;
               end
            end
            C_WB: state_ff <= C_EVAL;
            C_EVAL: begin
               priority if (blg_ff < sts.rd_lg) begin
                  blk_ff   <= bud_ff + bsize(sts.rd_lg);
                  state_ff <= C_NEXT2;
               end else if (blg_ff > sts.rd_lg) begin
                  blk_ff   <= bud_ff;
                  blg_ff   <= sts.rd_lg;
                  bfr_ff   <= sts.rd_free;
                  bud_ff   <= bud_ff + bsize(sts.rd_lg);
                  if (bud_ff + bsize(sts.rd_lg) >= OFF_W'(POOL_BYTES)) begin
                     state_ff <= C_END;
                  end else begin
                     cmd.op   <= CMD_READ;
                     cmd.addr <= slot_of(bud_ff + bsize(sts.rd_lg));
                     state_ff <= C_WB;
                  end
               end else if (bfr_ff && sts.rd_free) begin
                  cmd.op      <= CMD_WRITE;
                  cmd.addr    <= slot_of(blk_ff);
                  cmd.wr_free <= 1'b1;
                  cmd.wr_lg   <= blg_ff + 5'd1;
                  blk_ff      <= blk_ff + bsize(blg_ff + 5'd1);
                  state_ff    <= C_WMRG;
               end else begin
                  blk_ff   <= bud_ff + bsize(sts.rd_lg);
                  state_ff <= C_NEXT2;
               end
            end
            C_WMRG: begin
               if (blk_ff < OFF_W'(POOL_BYTES)) begin
                  quiet_ff <= 1'b0;
               end
               state_ff <= C_NEXT2;
            end
            C_NEXT2: begin
               state_ff <= (blk_ff >= OFF_W'(POOL_BYTES)) ? C_END : C_RA;
            end
            C_END: begin
               if (quiet_ff || pass_ff == (SLOT_W+1)'(NSLOTS)) begin
                  if (mode_ff) begin
                     rsucc_ff <= 1'b1;
                     state_ff <= S_RSP;
                  end else begin
                     state_ff <= F_START;
                  end
               end else begin
                  pass_ff  <= pass_ff + (SLOT_W+1)'(1);
                  state_ff <= C_START;
               end
            end
            // ---------------- release ----------------
            R_RD: begin
               if (cur_ff >= OFF_W'(POOL_BYTES) ||
                   cur_ff >= OFF_W'(rel_ff - 16'(HEADER_BYTES))) begin
                  state_ff <= R_MARK;
               end else begin
                  cmd.op   <= CMD_READ;
                  cmd.addr <= slot_of(cur_ff);
                  state_ff <= R_WT;
               end
            end
            R_WT: state_ff <= F_NRD;
            F_NRD: begin
               cur_ff   <= cur_ff + bsize(sts.rd_lg);
               state_ff <= R_RD;
            end
            R_MARK: begin
               if (cur_ff == OFF_W'(rel_ff - 16'(HEADER_BYTES)) &&
                   cur_ff < OFF_W'(POOL_BYTES)) begin
                  cmd.op   <= CMD_READ;
                  cmd.addr <= slot_of(cur_ff);
                  state_ff <= F_NWT;
               end else begin
                  state_ff <= S_RSP;
               end
            end
            F_NWT: state_ff <= C_NRD;
            C_NRD: begin
               cmd.op      <= CMD_WRITE;
               cmd.addr    <= slot_of(cur_ff);
               cmd.wr_free <= 1'b1;
               cmd.wr_lg   <= sts.rd_lg;
               pass_ff     <= '0;
               state_ff    <= C_NWT;
            end
            C_NWT: state_ff <= C_START;
            F_WMRG: state_ff <= S_IDLE;
            S_RSP: begin
               rvalid_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a 64 KiB pool with headers kept in a header memory.
// ----------------------------------------------------------------------------
// req carries one request: allocate (mode 0, elem_bytes * elem_count bytes
// plus a 16-byte header) or release (mode 1, payload offset). rsp returns
// one transfer per request with the payload offset and a success flag.
// One request is worked at a time. Latency is data dependent: every block
// header visit goes through the single header memory port, so a walk grows
// with the number of blocks, a split writes two headers per halving, and
// release repeats coalescing walks until one merges nothing or a pass limit is hit.
// Allocations that fail first run coalescing walks, then search again.
// After reset the pool is one free block; no clearing pass is needed.
// A stalled rsp holds its transfer; no new request is taken until it goes.
// ----------------------------------------------------------------------------
module buddy_block_allocator
   import bba_pkg::*;
(
   input logic     clock,
   input logic     reset,
   bba_req_if.sink   req,
   bba_rsp_if.source rsp
);
   mem_cmd_type cmd;
   mem_sts_type sts;

   bba_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .cmd(cmd), .sts(sts)
   );

   bba_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts)
   );
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and release requests into buddy_block_allocator under
// random gaps and stalls, keeps its own copy of the block chain and checks
// every response field by field against the predicted one.
// ----------------------------------------------------------------------------
module testbench
   import bba_pkg::*;
();

   localparam bit MODE_ALLOC   = 1'b0;
   localparam bit MODE_RELEASE = 1'b1;
   localparam int WATCHDOG_LIMIT = 400000;
   localparam int RANDOM_ITEMS   = 550;

   typedef struct {
      bit        mode;
      bit [16:0] elem_bytes;
      bit [16:0] elem_count;
      bit [15:0] release_offset;
   } heap_req_type;

   typedef struct {
      bit [15:0] payload_offset;
      bit        success;
   } heap_rsp_type;

   logic clock;
   logic reset;

   bba_req_if req ();
   bba_rsp_if rsp ();

   buddy_block_allocator u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // shadow copy of the block headers
   bit [4:0] chain_lg [NSLOTS];
   bit       chain_free [NSLOTS];

   heap_req_type  pending_reqs [$];
   heap_rsp_type  expected_rsps [$];
   bit [15:0]     live_offsets [$];
   int            error_count = 0;
   int            rsp_count = 0;
   int            push_count = 0;
   int            idle_cycles = 0;

   function automatic int slot(longint off);
      return int'((off / GRANULE_BYTES) % NSLOTS);
   endfunction

   function automatic longint blk_size(longint off);
      return longint'(1) << chain_lg[slot(off)];
   endfunction

   function automatic longint next_blk(longint off);
      return off + blk_size(off);
   endfunction

   function automatic bit split_down(longint off, longint need, output longint res);
      bit [4:0] l;
      while (need * 2 < blk_size(off) && blk_size(off) / 2 >= GRANULE_BYTES) begin
         l = chain_lg[slot(off)] - 5'd1;
         chain_lg[slot(off)] = l;
         off = next_blk(off);
         chain_lg[slot(off)] = l;
         chain_free[slot(off)] = 1;
      end
      res = off;
      return need <= blk_size(off);
   endfunction

   function automatic bit search_best_fit(longint need, output longint res);
      longint blk = 0;
      longint bud;
      longint best = 0;
      bit have = 0;
      bud = next_blk(0);
      res = 0;
      if (bud == POOL_BYTES && chain_free[0]) return split_down(0, need, res);
      while (blk < POOL_BYTES && bud < POOL_BYTES) begin
         if (chain_free[slot(blk)] && chain_free[slot(bud)] &&
             chain_lg[slot(blk)] == chain_lg[slot(bud)]) begin
            chain_lg[slot(blk)] = chain_lg[slot(blk)] + 5'd1;
            if (need <= blk_size(blk) && (!have || blk_size(blk) <= blk_size(best))) begin
               best = blk;
               have = 1;
            end
            blk = next_blk(bud);
            if (blk < POOL_BYTES) bud = next_blk(blk);
            continue;
         end
         if (chain_free[slot(blk)] && need <= blk_size(blk) &&
             (!have || blk_size(blk) < blk_size(best))) begin
            best = blk;
            have = 1;
         end
         if (chain_free[slot(bud)] && need <= blk_size(bud) &&
             (!have || blk_size(bud) < blk_size(best))) begin
            best = bud;
            have = 1;
         end
         if (chain_lg[slot(blk)] < chain_lg[slot(bud)]) begin
            blk = next_blk(bud);
            if (blk < POOL_BYTES) bud = next_blk(blk);
         end else begin
            blk = bud;
            bud = next_blk(bud);
         end
      end
      if (have) return split_down(best, need, res);
      return 0;
   endfunction

   function automatic void merge_until_quiet();
      longint blk;
      longint bud;
      bit quiet;
      for (int pass = 0; pass <= NSLOTS; pass++) begin
         blk = 0;
         bud = next_blk(0);
         quiet = 1;
         while (blk < POOL_BYTES && bud < POOL_BYTES) begin
            if (chain_lg[slot(blk)] < chain_lg[slot(bud)]) begin
               blk = next_blk(bud);
               if (blk < POOL_BYTES) bud = next_blk(blk);
            end else if (chain_lg[slot(blk)] > chain_lg[slot(bud)]) begin
               blk = bud;
               bud = next_blk(bud);
            end else if (chain_free[slot(blk)] && chain_free[slot(bud)]) begin
               chain_lg[slot(blk)] = chain_lg[slot(blk)] + 5'd1;
               blk = next_blk(blk);
               if (blk < POOL_BYTES) begin
                  bud = next_blk(blk);
                  quiet = 0;
               end
            end else begin
               blk = next_blk(bud);
               if (blk < POOL_BYTES) bud = next_blk(blk);
            end
         end
         if (quiet) return;
      end
   endfunction

   function automatic heap_rsp_type predict_heap(heap_req_type r);
      heap_rsp_type o;
      longint need;
      longint found;
      longint target;
      longint cur = 0;
      bit ok = 0;
      o.payload_offset = '0;
      o.success = 0;
      if (r.mode == MODE_ALLOC) begin
         need = longint'(r.elem_bytes) * longint'(r.elem_count) + HEADER_BYTES;
         if (need <= POOL_BYTES) begin
            ok = search_best_fit(need, found);
            if (!ok) begin
               merge_until_quiet();
               ok = search_best_fit(need, found);
            end
         end
         if (ok) begin
            chain_free[slot(found)] = 0;
            o.payload_offset = 16'(found + HEADER_BYTES);
            o.success = 1;
         end
      end else if (r.release_offset >= HEADER_BYTES) begin
         target = longint'(r.release_offset) - HEADER_BYTES;
         while (cur < POOL_BYTES && cur < target) cur = next_blk(cur);
         if (cur == target && cur < POOL_BYTES) begin
            chain_free[slot(cur)] = 1;
            merge_until_quiet();
            o.success = 1;
         end
      end
      return o;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // driver
   int  req_gap = 0;
   int  req_sent = 0;
   bit  next_valid;
   heap_req_type cur_req;

   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 0;
         req.mode <= MODE_ALLOC;
         req.elem_bytes <= '0;
         req.elem_count <= '0;
         req.release_offset <= '0;
      end else begin
         next_valid = req.valid;
         if (req.valid && req.ready) begin
            heap_rsp_type p;
            p = predict_heap(cur_req);
            expected_rsps.push_back(p);
            if (cur_req.mode == MODE_ALLOC && p.success && p.payload_offset != 0)
               live_offsets.push_back(p.payload_offset);
            if (cur_req.mode == MODE_RELEASE && p.success)
               for (int i = live_offsets.size() - 1; i >= 0; i--)
                  if (live_offsets[i] == cur_req.release_offset) live_offsets.delete(i);
            req_sent++;
            // stretch with no gaps in the middle of the random part
            req_gap = (req_sent > 150 && req_sent < 260) ? 0 : $urandom_range(0, 19);
            next_valid = 0;
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               req.mode <= cur_req.mode;
               req.elem_bytes <= cur_req.elem_bytes;
               req.elem_count <= cur_req.elem_count;
               req.release_offset <= cur_req.release_offset;
               next_valid = 1;
            end
         end
         req.valid <= next_valid;
      end
   end

   // monitor
   int rsp_stall = 0;
   int hold_off = 0;
   bit hold_done = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            heap_rsp_type e;
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("response with nothing expected");
            end else begin
               e = expected_rsps.pop_front();
               if (rsp.success !== e.success)
                  report_mismatch($sformatf("success %b, expected %b", rsp.success, e.success));
               if (rsp.payload_offset !== e.payload_offset)
                  report_mismatch($sformatf("payload_offset %0d, expected %0d",
                                            rsp.payload_offset, e.payload_offset));
            end
            rsp_stall = (rsp_count > 150 && rsp_count < 260) ? 0 : $urandom_range(0, 19);
            if (rsp_count == 300 && !hold_done) begin
               hold_off = 400;
               hold_done = 1;
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp.ready <= 0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp.ready <= 0;
         end else begin
            rsp.ready <= 1;
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[buddy_block_allocator] ERROR");
         $finish;
      end
   end

   task automatic push_alloc(int eb, int ec);
      heap_req_type r;
      r.mode = MODE_ALLOC;
      r.elem_bytes = 17'(eb);
      r.elem_count = 17'(ec);
      r.release_offset = 16'($urandom);
      pending_reqs.push_back(r);
      push_count++;
   endtask

   task automatic push_release(int off);
      heap_req_type r;
      r.mode = MODE_RELEASE;
      r.elem_bytes = 17'($urandom);
      r.elem_count = 17'($urandom);
      r.release_offset = 16'(off);
      pending_reqs.push_back(r);
      push_count++;
   endtask

   // directed releases need the allocations before them to have completed
   task automatic wait_drained();
      while (rsp_count < push_count)
         @(posedge clock);
   endtask

   task automatic push_random_alloc();
      case ($urandom_range(0, 9))
         0: push_alloc($urandom_range(1, 65536), $urandom_range(0, 2));
         1: push_alloc($urandom_range(1, 4), $urandom_range(0, 65536));
         default: push_alloc($urandom_range(1, 4096 >> $urandom_range(0, 12)),
                             $urandom_range(0, 8));
      endcase
   endtask

   initial begin
      int n;
      reset = 1;
      repeat (6) @(posedge clock);
      reset <= 0;

      // directed part
      push_alloc(65520, 1);             // exactly the whole pool
      wait_drained();
      push_release(16);
      push_alloc(65536, 1);             // too large
      push_alloc(1, 65536);             // count top bit, too large
      push_alloc(65536, 0);             // zero count, header only
      push_alloc(1, 0);
      push_alloc(1, 1);
      push_alloc(200, 3);
      push_alloc(1000, 10);
      push_release(0);                  // below the header
      push_release(15);
      push_release(17);                 // not a block start
      push_release(65535);
      wait_drained();
      n = live_offsets.size();
      for (int i = 0; i < n; i++) push_release(live_offsets[i]);
      push_release(16);                 // release of a free block
      for (int i = 0; i < 5; i++) push_alloc(1024, 1);
      wait_drained();
      push_release(live_offsets[1]);
      push_release(live_offsets[2]);
      push_alloc(3000, 1);

      // random part
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         while (pending_reqs.size() >= 2) @(posedge clock);
         n = $urandom_range(0, 99);
         if (n < 55 || (n < 90 && live_offsets.size() == 0)) push_random_alloc();
         else if (n < 90) push_release(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
         else if (n < 95) push_release($urandom_range(0, 65535));
         else push_release(16 * $urandom_range(0, 4095) + 16);
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("[buddy_block_allocator] OK");
      end else begin
         $display("[buddy_block_allocator] ERROR");
      end
      $finish;
   end

   initial begin
      for (int i = 0; i < NSLOTS; i++) begin
         chain_lg[i] = '0;
         chain_free[i] = 0;
      end
      chain_lg[0] = 5'(POOL_LOG2);
      chain_free[0] = 1;
   end

endmodule
